/* rtl/output_interlock_timer_controller_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the output interlock timer controller
// Shared property forms that the top level uses for its checks.
// ----------------------------------------------------------------------------
`ifndef OUTPUT_INTERLOCK_TIMER_CONTROLLER_MACROS_SVH
`define OUTPUT_INTERLOCK_TIMER_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OITC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled during reset.
`define OITC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

/* rtl/oitc_pkg.sv */
// ----------------------------------------------------------------------------
// oitc_pkg
// Types, register codes and field helpers of the output interlock timer
// controller.
// ----------------------------------------------------------------------------
package oitc_pkg;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_OUTPUT_TYPES    = 3'd0;
  localparam logic [2:0] REG_INTERLOCK_TABLE = 3'd1;
  localparam logic [2:0] REG_TIMER_SECS_0_1  = 3'd2;
  localparam logic [2:0] REG_TIMER_SECS_2_3  = 3'd3;
  localparam logic [2:0] REG_TIMER_SECS_4_5  = 3'd4;
  localparam logic [2:0] REG_TIMER_SECS_6_7  = 3'd5;
  localparam logic [2:0] REG_MOTOR_DELAY     = 3'd6;
  localparam logic [2:0] REG_RELAY_DELAY     = 3'd7;

  // Output type codes; every other code behaves as a relay.
  localparam logic [3:0] TYPE_MOTOR = 4'd1;
  localparam logic [3:0] TYPE_TIMER = 4'd2;

  localparam logic [25:0] MS_PER_SEC = 26'd1000;

  // Reset values of the configuration registers.
  localparam logic [31:0] OUTPUT_TYPES_RST    = 32'h0000_0000;
  localparam logic [23:0] INTERLOCK_TABLE_RST = 24'hFA_C688;
  localparam logic [31:0] TIMER_SECS_RST      = 32'h003C_003C;
  localparam logic [15:0] MOTOR_DELAY_RST     = 16'd2000;
  localparam logic [15:0] RELAY_DELAY_RST     = 16'd500;

  typedef struct packed {
    logic        operation;
    logic [7:0]  event_id;
    logic [2:0]  output_index;
    logic        command;
    logic [15:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] event_out_id;
    logic [2:0] changed_output;
    logic [3:0] changed_type;
    logic       new_state;
    logic       last_event;
  } out_item_t;

  typedef struct packed {
    logic [31:0]      output_types;
    logic [23:0]      interlock_table;
    logic [3:0][31:0] timer_secs;
    logic [15:0]      motor_delay_ms;
    logic [15:0]      relay_delay_ms;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic do_cmd;
    logic scan_step;
    logic emit_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic scan_last;
    logic mask_empty;
    logic mask_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [3:0] type_of(input logic [31:0] types, input logic [2:0] idx);
    return types[{idx, 2'b00} +: 4];
  endfunction

  function automatic logic [2:0] partner_of(input logic [23:0] table_bits,
                                            input logic [2:0] idx);
    logic [4:0] base;
    base = 5'(idx) * 5'd3;
    return table_bits[base +: 3];
  endfunction

  function automatic logic [15:0] timer_of(input logic [3:0][31:0] secs,
                                           input logic [2:0] idx);
    logic [31:0] pair;
    pair = secs[idx[2:1]];
    return idx[0] ? pair[31:16] : pair[15:0];
  endfunction

endpackage

/* rtl/oitc_regs.sv */
// ----------------------------------------------------------------------------
// oitc_regs
// Configuration register file; flags a write of the output types register.
// ----------------------------------------------------------------------------
module oitc_regs (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  output oitc_pkg::cfg_t cfg,
  output logic           clear_timing
);

  // A types write clears all timing state at the same edge.
  assign clear_timing = cfg_we && (cfg_index == oitc_pkg::REG_OUTPUT_TYPES);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.output_types    <= oitc_pkg::OUTPUT_TYPES_RST;
      cfg.interlock_table <= oitc_pkg::INTERLOCK_TABLE_RST;
      cfg.timer_secs      <= {4{oitc_pkg::TIMER_SECS_RST}};
      cfg.motor_delay_ms  <= oitc_pkg::MOTOR_DELAY_RST;
      cfg.relay_delay_ms  <= oitc_pkg::RELAY_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        oitc_pkg::REG_OUTPUT_TYPES:    cfg.output_types    <= cfg_data;
        oitc_pkg::REG_INTERLOCK_TABLE: cfg.interlock_table <= cfg_data[23:0];
        oitc_pkg::REG_TIMER_SECS_0_1:  cfg.timer_secs[0]   <= cfg_data;
        oitc_pkg::REG_TIMER_SECS_2_3:  cfg.timer_secs[1]   <= cfg_data;
        oitc_pkg::REG_TIMER_SECS_4_5:  cfg.timer_secs[2]   <= cfg_data;
        oitc_pkg::REG_TIMER_SECS_6_7:  cfg.timer_secs[3]   <= cfg_data;
        oitc_pkg::REG_MOTOR_DELAY:     cfg.motor_delay_ms  <= cfg_data[15:0];
        oitc_pkg::REG_RELAY_DELAY:     cfg.relay_delay_ms  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/oitc_ctrl.sv */
// ----------------------------------------------------------------------------
// oitc_ctrl
// Sequencer: takes an item, runs the command or the tick scan, then hands
// the recorded events to the output register one at a time.
// ----------------------------------------------------------------------------
module oitc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_tick,
  output logic                 in_ready,
  input  oitc_pkg::dp_status_t status,
  output oitc_pkg::ctrl_cmd_t  cmd
);

  oitc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oitc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      oitc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = in_tick ? oitc_pkg::ST_SCAN : oitc_pkg::ST_CMD;
        end
      end
      oitc_pkg::ST_CMD: begin
        state_next = oitc_pkg::ST_EMIT;
      end
      oitc_pkg::ST_SCAN: begin
        if (status.scan_last) begin
          state_next = oitc_pkg::ST_EMIT;
        end
      end
      oitc_pkg::ST_EMIT: begin
        if (status.mask_empty) begin
          state_next = oitc_pkg::ST_IDLE;
        end else if (status.out_free && status.mask_last) begin
          state_next = oitc_pkg::ST_IDLE;
        end
      end
      default: state_next = oitc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    case (state)
      oitc_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      oitc_pkg::ST_CMD: begin
        cmd.do_cmd = 1'b1;
      end
      oitc_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      oitc_pkg::ST_EMIT: begin
        cmd.emit_load = status.out_free && !status.mask_empty;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/oitc_dp.sv */
// ----------------------------------------------------------------------------
// oitc_dp
// Datapath: per-output state and timers, command and tick logic, the
// event mask and the output register.
// ----------------------------------------------------------------------------
module oitc_dp #(
  parameter int NUM_OUTPUTS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  oitc_pkg::in_item_t   in_data,
  input  oitc_pkg::cfg_t       cfg,
  input  logic                 clear_timing,
  input  oitc_pkg::ctrl_cmd_t  cmd,
  output oitc_pkg::dp_status_t status,
  input  logic                 out_ready,
  output logic                 out_valid,
  output oitc_pkg::out_item_t  out_data
);

  localparam int ACTIVE = (NUM_OUTPUTS < 8) ? NUM_OUTPUTS : 8;
  localparam int IDXW = $clog2(ACTIVE);
  localparam logic [3:0] ACTIVE_W = 4'(ACTIVE);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ACTIVE - 1);

  oitc_pkg::in_item_t item;
  logic [IDXW-1:0]    scan_idx;
  logic [ACTIVE-1:0]  on_state;
  logic [ACTIVE-1:0]  pend_state;
  logic [ACTIVE-1:0]  mask;
  logic [7:0]         pend_id  [ACTIVE];
  logic [31:0]        elapsed  [ACTIVE];
  logic [25:0]        armed    [ACTIVE];

  // Command decode.
  logic            cmd_in_range;
  logic [IDXW-1:0] cmd_sel;
  logic [3:0]      cmd_type;
  logic [2:0]      partner;
  logic            partner_ok;
  logic [IDXW-1:0] partner_sel;
  logic [25:0]     timer_ms;
  logic [25:0]     il_delay;
  logic            set_en;
  logic [IDXW-1:0] set_sel;
  logic            set_val;
  logic            arm_en;
  logic            arm_state;
  logic [25:0]     arm_ms;
  logic            disarm;

  // Tick and emit.
  logic [31:0]       elapsed_sum;
  logic              fire;
  logic [IDXW-1:0]   emit_sel;
  logic [ACTIVE-1:0] mask_rest;

  assign cmd_in_range = {1'b0, item.output_index} < ACTIVE_W;
  assign cmd_sel      = item.output_index[IDXW-1:0];
  assign cmd_type     = oitc_pkg::type_of(cfg.output_types, item.output_index);
  assign partner      = oitc_pkg::partner_of(cfg.interlock_table, item.output_index);
  assign partner_ok   = (partner != item.output_index) && ({1'b0, partner} < ACTIVE_W);
  assign partner_sel  = partner[IDXW-1:0];
  assign timer_ms     = 26'(oitc_pkg::timer_of(cfg.timer_secs, item.output_index))
                        * oitc_pkg::MS_PER_SEC;
  assign il_delay     = (cmd_type == oitc_pkg::TYPE_MOTOR) ? 26'(cfg.motor_delay_ms)
                                                           : 26'(cfg.relay_delay_ms);

  always_comb begin
    set_en    = 1'b0;
    set_sel   = cmd_sel;
    set_val   = item.command;
    arm_en    = 1'b0;
    arm_state = 1'b0;
    arm_ms    = timer_ms;
    disarm    = 1'b0;
    if (cmd_in_range) begin
      if (cmd_type == oitc_pkg::TYPE_TIMER) begin
        set_en = on_state[cmd_sel] != item.command;
        arm_en = item.command;
        disarm = !item.command;
      end else if (item.command && partner_ok && on_state[partner_sel]) begin
        // Partner goes off now; this output follows after the interlock delay.
        set_en    = 1'b1;
        set_sel   = partner_sel;
        set_val   = 1'b0;
        arm_en    = 1'b1;
        arm_state = 1'b1;
        arm_ms    = il_delay;
      end else begin
        set_en = on_state[cmd_sel] != item.command;
      end
    end
  end

  assign elapsed_sum = elapsed[scan_idx] + 32'(item.elapsed_ms);
  assign fire        = (armed[scan_idx] != '0) && (elapsed_sum > 32'(armed[scan_idx]));

  // Lowest pending event goes out first.
  always_comb begin
    emit_sel = '0;
    for (int i = ACTIVE - 1; i >= 0; i--) begin
      if (mask[i]) begin
        emit_sel = IDXW'(i);
      end
    end
  end

  assign mask_rest = mask & (mask - ACTIVE'(1));

  assign status.is_tick    = item.operation;
  assign status.scan_last  = scan_idx == LAST_IDX;
  assign status.mask_empty = mask == '0;
  assign status.mask_last  = mask_rest == '0;
  assign status.out_free   = !out_valid || out_ready;

  // Control state and the armed delays.
  always_ff @(posedge clk) begin
    if (rst) begin
      on_state  <= '0;
      mask      <= '0;
      scan_idx  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < ACTIVE; i++) begin
        armed[i] <= '0;
      end
    end else begin
      if (clear_timing) begin
        for (int i = 0; i < ACTIVE; i++) begin
          armed[i] <= '0;
        end
      end
      if (cmd.load_item) begin
        mask     <= '0;
        scan_idx <= '0;
      end
      if (cmd.do_cmd) begin
        if (set_en) begin
          on_state[set_sel] <= set_val;
          mask[set_sel]     <= 1'b1;
        end
        if (arm_en) begin
          armed[cmd_sel] <= arm_ms;
        end else if (disarm) begin
          armed[cmd_sel] <= '0;
        end
      end
      if (cmd.scan_step) begin
        scan_idx <= scan_idx + IDXW'(1);
        if (fire) begin
          armed[scan_idx] <= '0;
          if (on_state[scan_idx] != pend_state[scan_idx]) begin
            on_state[scan_idx] <= pend_state[scan_idx];
            mask[scan_idx]     <= 1'b1;
          end
        end
      end
      if (cmd.emit_load) begin
        mask      <= mask_rest;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
    if (clear_timing) begin
      for (int i = 0; i < ACTIVE; i++) begin
        elapsed[i] <= '0;
      end
    end
    if (cmd.do_cmd && arm_en) begin
      elapsed[cmd_sel]    <= '0;
      pend_id[cmd_sel]    <= item.event_id;
      pend_state[cmd_sel] <= arm_state;
    end
    if (cmd.scan_step) begin
      elapsed[scan_idx] <= elapsed_sum;
    end
    if (cmd.emit_load) begin
      out_data.event_out_id   <= item.operation ? pend_id[emit_sel] : item.event_id;
      out_data.changed_output <= 3'(emit_sel);
      out_data.changed_type   <= oitc_pkg::type_of(cfg.output_types, 3'(emit_sel));
      out_data.new_state      <= on_state[emit_sel];
      out_data.last_event     <= mask_rest == '0;
    end
  end

endmodule

/* rtl/output_interlock_timer_controller.sv */
// ----------------------------------------------------------------------------
// output_interlock_timer_controller
// Bank of on/off outputs with per-output type, interlock partner and timer.
// ----------------------------------------------------------------------------
// A command item is accepted, executed and then yields at most one event; a
// tick item is accepted, then scans every active output (at most eight) and
// then hands out one event for each output that changed. The emit step is
// always entered, even when nothing changed. The tick scan visits one output
// per cycle through a single 32-bit add and compare, and the output register
// takes one event per cycle while it is empty or out_ready is high. Each
// input transaction yields zero or more output transactions, the final one
// marked by last_event. The next input transaction is taken while the last
// event still waits in the output register. Configuration writes take effect
// at once; a write of the output types register cancels every pending timed
// change.
// ----------------------------------------------------------------------------
module output_interlock_timer_controller #(
  parameter int NUM_OUTPUTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  oitc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output oitc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  oitc_pkg::cfg_t       cfg;
  logic                 clear_timing;
  oitc_pkg::ctrl_cmd_t  ctrl_cmd;
  oitc_pkg::dp_status_t dp_status;

  // Configuration registers.
  oitc_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg),
    .clear_timing (clear_timing)
  );

  // Sequencer that steps each transaction through execute, scan and emit.
  oitc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_tick  (in_data.operation),
    .in_ready (in_ready),
    .status   (dp_status),
    .cmd      (ctrl_cmd)
  );

  // Output states, timers, event mask and the output register.
  oitc_dp #(
    .NUM_OUTPUTS (NUM_OUTPUTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_data      (in_data),
    .cfg          (cfg),
    .clear_timing (clear_timing),
    .cmd          (ctrl_cmd),
    .status       (dp_status),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_data     (out_data)
  );

`include "output_interlock_timer_controller_macros.svh"

  // Once a transaction is taken, the block is not ready in the following cycle.
  `OITC_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  // An event is only loaded when one is recorded.
  `OITC_ASSERT_IMPLIES(a_emit_has_event, clk, rst, ctrl_cmd.emit_load, !dp_status.mask_empty)
  // The scan runs only for tick transactions.
  `OITC_ASSERT_IMPLIES(a_scan_only_tick, clk, rst, ctrl_cmd.scan_step, dp_status.is_tick)
  // A loaded event is presented in the following cycle.
  `OITC_ASSERT_NEXT(a_emit_shows, clk, rst, ctrl_cmd.emit_load, out_valid)

endmodule
